>>> src/tpa_pkg.sv
// Shared types and constants for the triangle primitive assembler.
`default_nettype none
package tpa_pkg;
	localparam int unsigned TriNumberBits = 24;
	localparam int unsigned PosBits = 32;

	typedef logic [PosBits-1:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} vec_t;

	typedef enum logic [1:0] {
		MODE_NONE  = 2'd0,
		MODE_LIST  = 2'd1,
		MODE_FAN   = 2'd2,
		MODE_STRIP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		SLOT_C0  = 3'd0,
		SLOT_C1  = 3'd1,
		SLOT_C2  = 3'd2,
		SLOT_MIN = 3'd3,
		SLOT_MAX = 3'd4
	} slot_t;

	// IEEE a < b on bit patterns; NaN and signed zeros never compare
	function automatic logic fless(input word_t a, input word_t b);
		logic [PosBits-1:0] ka;
		logic [PosBits-1:0] kb;
		logic               nan;
		logic               zz;
		ka  = a[PosBits-1] ? ~a : (a | {1'b1, {(PosBits-1){1'b0}}});
		kb  = b[PosBits-1] ? ~b : (b | {1'b1, {(PosBits-1){1'b0}}});
		nan = (a[PosBits-2:0] > 31'h7F80_0000) || (b[PosBits-2:0] > 31'h7F80_0000);
		zz  = ((a | b) & 32'h7FFF_FFFF) == '0;
		return !nan && !zz && (ka < kb);
	endfunction
endpackage
`default_nettype wire

>>> src/tpa_assembly.sv
// Run state, vertex history and triangle forming with bounding box.
`default_nettype none
module tpa_assembly #(
	parameter int unsigned TRI_NUMBER_BITS = tpa_pkg::TriNumberBits
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_take,
	input  wire  [1:0]                 mode,
	input  wire                        end_of_run,
	input  wire  tpa_pkg::vec_t        pos,
	input  wire                        tri_take,
	output logic                       tri_valid,
	output tpa_pkg::vec_t              c0,
	output tpa_pkg::vec_t              c1,
	output tpa_pkg::vec_t              c2,
	output tpa_pkg::vec_t              lo,
	output tpa_pkg::vec_t              hi,
	output logic [TRI_NUMBER_BITS-1:0] num
);
	tpa_pkg::vec_t pivot_q, older_q, newer_q;
	logic [1:0] runpos_q, runpos_d;
	logic parity_q, parity_d;
	logic [TRI_NUMBER_BITS-1:0] count_q;
	tpa_pkg::vec_t a, b;
	logic emit, swap;

	function automatic tpa_pkg::word_t bmin(input tpa_pkg::word_t p, input tpa_pkg::word_t q,
		input tpa_pkg::word_t r);
		tpa_pkg::word_t m;
		m = p;
		if (tpa_pkg::fless(q, m)) m = q;
		if (tpa_pkg::fless(r, m)) m = r;
		return m;
	endfunction

	function automatic tpa_pkg::word_t bmax(input tpa_pkg::word_t p, input tpa_pkg::word_t q,
		input tpa_pkg::word_t r);
		tpa_pkg::word_t m;
		m = p;
		if (tpa_pkg::fless(m, q)) m = q;
		if (tpa_pkg::fless(m, r)) m = r;
		return m;
	endfunction

	// pick the corners for this vertex
	always_comb begin
		emit = in_take && (mode != tpa_pkg::MODE_NONE) && (runpos_q == 2'd2);
		a    = (mode == tpa_pkg::MODE_FAN) ? pivot_q : older_q;
		b    = newer_q;
		swap = (mode == tpa_pkg::MODE_STRIP) && parity_q;
	end

	// work out the next run position and strip parity; end of run clears both
	always_comb begin
		runpos_d = runpos_q;
		parity_d = parity_q;
		if (mode != tpa_pkg::MODE_NONE) begin
			unique case (runpos_q)
				2'd0: runpos_d = 2'd1;
				2'd1: runpos_d = 2'd2;
				default: begin
					if (mode == tpa_pkg::MODE_LIST) runpos_d = 2'd0;
					if (mode == tpa_pkg::MODE_STRIP) parity_d = ~parity_q;
				end
			endcase
		end
		if (end_of_run) begin
			runpos_d = '0;
			parity_d = 1'b0;
		end
	end

	// advance run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_q  <= '0;
			older_q  <= '0;
			newer_q  <= '0;
			runpos_q <= '0;
			parity_q <= 1'b0;
			count_q  <= '0;
		end else if (in_take) begin
			runpos_q <= runpos_d;
			parity_q <= parity_d;
			if (mode != tpa_pkg::MODE_NONE) begin
				unique case (runpos_q)
					2'd0: begin
						if (mode == tpa_pkg::MODE_FAN) pivot_q <= pos;
						else older_q <= pos;
					end
					2'd1: begin
						newer_q <= pos;
					end
					default: begin
						count_q <= count_q + 1'b1;
						if (mode != tpa_pkg::MODE_LIST) newer_q <= pos;
						if (mode == tpa_pkg::MODE_STRIP) older_q <= newer_q;
					end
				endcase
			end
		end
	end

	// hold the triangle flag until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tri_valid <= 1'b0;
		else if (emit) tri_valid <= 1'b1;
		else if (tri_take) tri_valid <= 1'b0;
	end

	// register the triangle and its bounds
	always_ff @(posedge clk) begin
		if (emit) begin
			c0  <= a;
			c1  <= swap ? pos : b;
			c2  <= swap ? b : pos;
			num <= count_q;
			lo  <= tpa_pkg::vec_t'({bmin(a.x, b.x, pos.x), bmin(a.y, b.y, pos.y),
				bmin(a.z, b.z, pos.z)});
			hi  <= tpa_pkg::vec_t'({bmax(a.x, b.x, pos.x), bmax(a.y, b.y, pos.y),
				bmax(a.z, b.z, pos.z)});
		end
	end
endmodule
`default_nettype wire

>>> src/tpa_emitter.sv
// Sequences the five results of a triangle onto the output channel.
`default_nettype none
module tpa_emitter #(
	parameter int unsigned TRI_NUMBER_BITS = tpa_pkg::TriNumberBits
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        tri_valid,
	input  wire  tpa_pkg::vec_t        c0,
	input  wire  tpa_pkg::vec_t        c1,
	input  wire  tpa_pkg::vec_t        c2,
	input  wire  tpa_pkg::vec_t        lo,
	input  wire  tpa_pkg::vec_t        hi,
	input  wire  [TRI_NUMBER_BITS-1:0] num,
	output logic                       tri_take,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic [2:0]                 slot,
	output tpa_pkg::vec_t              value,
	output logic [23:0]                triangle_number,
	output logic                       last
);
	tpa_pkg::vec_t c0_q, c1_q, c2_q, lo_q, hi_q;
	logic [TRI_NUMBER_BITS-1:0] num_q;
	logic [2:0] slot_q;
	logic done;

	// take a waiting triangle when idle or as the final result leaves
	assign done     = out_valid && !out_stall && (slot_q == tpa_pkg::SLOT_MAX);
	assign tri_take = tri_valid && (!out_valid || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			slot_q    <= tpa_pkg::SLOT_C0;
		end else if (tri_take) begin
			out_valid <= 1'b1;
			slot_q    <= tpa_pkg::SLOT_C0;
		end else if (out_valid && !out_stall) begin
			if (done) out_valid <= 1'b0;
			else slot_q <= slot_q + 3'd1;
		end
	end

	// hold the triangle
	always_ff @(posedge clk) begin
		if (tri_take) begin
			c0_q <= c0; c1_q <= c1; c2_q <= c2; lo_q <= lo; hi_q <= hi;
			num_q <= num;
		end
	end

	always_comb begin
		unique case (slot_q)
			tpa_pkg::SLOT_C0:  value = c0_q;
			tpa_pkg::SLOT_C1:  value = c1_q;
			tpa_pkg::SLOT_C2:  value = c2_q;
			tpa_pkg::SLOT_MIN: value = lo_q;
			default:           value = hi_q;
		endcase
	end

	assign slot = slot_q;
	assign last = (slot_q == tpa_pkg::SLOT_MAX);
	assign triangle_number = 24'(num_q);
endmodule
`default_nettype wire

>>> src/triangle_primitive_assembler.sv
// Top level of the triangle primitive assembler.
`default_nettype none
// Takes one vertex per item and forms triangles for list, fan and strip runs; each
// triangle leaves as five results (three corners in winding order, bounds minimum,
// bounds maximum), one per cycle while the output does not stall. The triangle and
// its bounds are registered in the cycle after acceptance and wait there until the
// result sequencer takes them; with the sequencer idle the first result is offered
// once the sequencer has registered them in turn. One triangle can wait while another
// drains, so any vertex is held off only while a triangle waits that the sequencer
// cannot take; result stalls lengthen that wait.
module triangle_primitive_assembler #(
	parameter int unsigned TRI_NUMBER_BITS = tpa_pkg::TriNumberBits
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  mode,
	input  wire         end_of_run,
	input  wire  [31:0] pos_x,
	input  wire  [31:0] pos_y,
	input  wire  [31:0] pos_z,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  slot,
	output logic [31:0] out_x,
	output logic [31:0] out_y,
	output logic [31:0] out_z,
	output logic [23:0] triangle_number,
	output logic        last
);
	tpa_pkg::vec_t pos, c0, c1, c2, lo, hi, value;
	logic [TRI_NUMBER_BITS-1:0] num;
	logic tri_valid, tri_take, in_take;

	// stall while a triangle waits and the sequencer cannot take it
	assign in_stall = tri_valid && !tri_take;
	assign in_take  = in_valid && !in_stall;
	assign pos      = tpa_pkg::vec_t'({pos_x, pos_y, pos_z});

	tpa_assembly #(.TRI_NUMBER_BITS(TRI_NUMBER_BITS)) u_asm (
		.clk, .arst_n, .in_take, .mode, .end_of_run, .pos, .tri_take,
		.tri_valid, .c0, .c1, .c2, .lo, .hi, .num
	);

	tpa_emitter #(.TRI_NUMBER_BITS(TRI_NUMBER_BITS)) u_emit (
		.clk, .arst_n, .tri_valid, .c0, .c1, .c2, .lo, .hi, .num,
		.tri_take, .out_valid, .out_stall, .slot, .value, .triangle_number, .last
	);

	assign out_x = value.x;
	assign out_y = value.y;
	assign out_z = value.z;

	// last marks only the maximum-bound result
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (slot == tpa_pkg::SLOT_MAX)))
		else $error("last flag out of step with slot");
	// a held result does not move while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(slot)))
		else $error("stalled result changed");
	// a waiting triangle is kept until the sequencer takes it
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(tri_valid && in_stall) |=> tri_valid)
		else $error("pending triangle dropped");
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the triangle primitive assembler.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	typedef struct packed {
		logic [2:0]  slot;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [23:0] num;
		logic        last;
	} tri_result_t;

	class triangle_scoreboard;
		tpa_pkg::vec_t fan_pivot;
		tpa_pkg::vec_t hist_old;
		tpa_pkg::vec_t hist_new;
		logic [1:0]    run_pos;
		logic          parity;
		logic [23:0]   tri_count;
		tri_result_t   pending[$];
		int            errors;

		function void clear();
			fan_pivot = '0;
			hist_old  = '0;
			hist_new  = '0;
			run_pos   = '0;
			parity    = 1'b0;
			tri_count = '0;
			errors    = 0;
			pending.delete();
		endfunction

		// IEEE strict less-than on bit patterns; NaN and zero pairs never order
		function bit lt(logic [31:0] a, logic [31:0] b);
			logic [31:0] ka;
			logic [31:0] kb;
			ka = a[31] ? ~a : (a | 32'h8000_0000);
			kb = b[31] ? ~b : (b | 32'h8000_0000);
			if ((a & 32'h7FFF_FFFF) > 32'h7F80_0000) return 0;
			if ((b & 32'h7FFF_FFFF) > 32'h7F80_0000) return 0;
			if (((a | b) & 32'h7FFF_FFFF) == 0) return 0;
			return ka < kb;
		endfunction

		function void push(tpa_pkg::slot_t s, tpa_pkg::vec_t v, bit lst);
			tri_result_t r;
			r.slot = s;
			r.x    = v.x;
			r.y    = v.y;
			r.z    = v.z;
			r.num  = tri_count;
			r.last = lst;
			pending = {pending, r};
		endfunction

		// queue the five results of one triangle, bounds from arrival order
		function void add_triangle(tpa_pkg::vec_t a, tpa_pkg::vec_t b, tpa_pkg::vec_t c,
				bit swap);
			logic [31:0]   av[3];
			logic [31:0]   bv[3];
			logic [31:0]   cv[3];
			logic [31:0]   lo[3];
			logic [31:0]   hi[3];
			tpa_pkg::vec_t vlo;
			tpa_pkg::vec_t vhi;
			av = '{a.x, a.y, a.z};
			bv = '{b.x, b.y, b.z};
			cv = '{c.x, c.y, c.z};
			for (int i = 0; i < 3; i++) begin
				lo[i] = av[i];
				hi[i] = av[i];
				if (lt(bv[i], lo[i])) lo[i] = bv[i];
				if (lt(hi[i], bv[i])) hi[i] = bv[i];
				if (lt(cv[i], lo[i])) lo[i] = cv[i];
				if (lt(hi[i], cv[i])) hi[i] = cv[i];
			end
			vlo = {lo[0], lo[1], lo[2]};
			vhi = {hi[0], hi[1], hi[2]};
			push(tpa_pkg::SLOT_C0, a, 0);
			push(tpa_pkg::SLOT_C1, swap ? c : b, 0);
			push(tpa_pkg::SLOT_C2, swap ? b : c, 0);
			push(tpa_pkg::SLOT_MIN, vlo, 0);
			push(tpa_pkg::SLOT_MAX, vhi, 1);
			tri_count = tri_count + 24'd1;
		endfunction

		function void note_vertex(tpa_pkg::mode_t m, bit eor, tpa_pkg::vec_t v);
			tpa_pkg::vec_t o;
			tpa_pkg::vec_t n;
			o = hist_old;
			n = hist_new;
			case (m)
				tpa_pkg::MODE_LIST: begin
					if (run_pos == 2'd0) begin
						hist_old = v; run_pos = 2'd1;
					end else if (run_pos == 2'd1) begin
						hist_new = v; run_pos = 2'd2;
					end else begin
						add_triangle(o, n, v, 0); run_pos = 2'd0;
					end
				end
				tpa_pkg::MODE_FAN: begin
					if (run_pos == 2'd0) begin
						fan_pivot = v; run_pos = 2'd1;
					end else if (run_pos == 2'd1) begin
						hist_new = v; run_pos = 2'd2;
					end else begin
						add_triangle(fan_pivot, n, v, 0); hist_new = v;
					end
				end
				tpa_pkg::MODE_STRIP: begin
					if (run_pos == 2'd0) begin
						hist_old = v; run_pos = 2'd1;
					end else if (run_pos == 2'd1) begin
						hist_new = v; run_pos = 2'd2;
					end else begin
						add_triangle(o, n, v, parity);
						parity = ~parity;
						hist_old = n;
						hist_new = v;
					end
				end
				default: ;
			endcase
			if (eor) begin
				run_pos = 2'd0;
				parity = 1'b0;
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h, want %h", what, got, want);
			errors++;
		endtask

		task check_result(tri_result_t got);
			tri_result_t w;
			if (pending.size() == 0) begin
				report("unexpected result slot", 32'(got.slot), '0);
				return;
			end
			w = pending.pop_front();
			if (got.slot !== w.slot) report("slot", 32'(got.slot), 32'(w.slot));
			if (got.x !== w.x) report("x", got.x, w.x);
			if (got.y !== w.y) report("y", got.y, w.y);
			if (got.z !== w.z) report("z", got.z, w.z);
			if (got.num !== w.num) report("triangle_number", 32'(got.num), 32'(w.num));
			if (got.last !== w.last) report("last", 32'(got.last), 32'(w.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic        end_of_run;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  slot;
	logic [31:0] out_x;
	logic [31:0] out_y;
	logic [31:0] out_z;
	logic [23:0] triangle_number;
	logic        last;

	triangle_scoreboard board;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  quiet_cycles;

	triangle_primitive_assembler i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .end_of_run(end_of_run),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.slot(slot), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.triangle_number(triangle_number), .last(last)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// check results and note accepted vertices at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_vertex(tpa_pkg::mode_t'(mode), end_of_run, {pos_x, pos_y, pos_z});
			end
			if (out_valid && !out_stall) begin
				board.check_result({slot, out_x, out_y, out_z, triangle_number, last});
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stall the result side at random on the falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if (quiet_cycles > 4000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// offer one vertex and hold it until taken
	task automatic send_vertex(tpa_pkg::mode_t m, bit eor, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		end_of_run <= eor;
		pos_x      <= x;
		pos_y      <= y;
		pos_z      <= z;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_float();
		logic [31:0] specials[10];
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF,
			32'h3F80_0000, 32'hBF80_0000};
		if ($urandom_range(3) == 0) return specials[$urandom_range(9)];
		return $urandom();
	endfunction

	task automatic random_vertices(int count);
		tpa_pkg::mode_t m;
		int             len;
		int             sent;
		sent = 0;
		while (sent < count) begin
			// mostly clean runs of one mode, sometimes noise and mode changes
			m = tpa_pkg::mode_t'($urandom_range(3));
			len = $urandom_range(1, 9);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(9) == 0) m = tpa_pkg::mode_t'($urandom_range(3));
				send_vertex(m, (i == len - 1) || ($urandom_range(19) == 0),
					pick_float(), pick_float(), pick_float());
				sent++;
			end
		end
	endtask

	// drop valid and wait for every expected result
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		board = new();
		board.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = tpa_pkg::MODE_NONE;
		end_of_run = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each mode, extremes, zero signs, NaN, mode change, list drop
		send_vertex(tpa_pkg::MODE_NONE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_vertex(tpa_pkg::MODE_LIST, 0, 32'h0000_0000, 32'h7FC0_0000, 32'h3F80_0000);
		send_vertex(tpa_pkg::MODE_LIST, 0, 32'h8000_0000, 32'hBF80_0000, 32'h7F80_0000);
		send_vertex(tpa_pkg::MODE_LIST, 0, 32'hFFFF_FFFF, 32'h4000_0000, 32'hFF80_0000);
		send_vertex(tpa_pkg::MODE_LIST, 0, 32'h1, 32'h2, 32'h3);
		send_vertex(tpa_pkg::MODE_LIST, 1, 32'h4, 32'h5, 32'h6);
		send_vertex(tpa_pkg::MODE_FAN, 0, 32'h3F80_0000, 32'h0, 32'h0);
		send_vertex(tpa_pkg::MODE_FAN, 0, 32'h4000_0000, 32'hBF80_0000, 32'h7F7F_FFFF);
		send_vertex(tpa_pkg::MODE_FAN, 0, 32'hC000_0000, 32'h8000_0001, 32'hFF7F_FFFF);
		send_vertex(tpa_pkg::MODE_FAN, 0, 32'h4040_0000, 32'h7F80_0001, 32'h0);
		send_vertex(tpa_pkg::MODE_FAN, 1, 32'h4080_0000, 32'h8000_0000, 32'h1);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h1, 32'h1, 32'h1);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h2, 32'h2, 32'h2);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h3, 32'h3, 32'h3);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h4, 32'h4, 32'h4);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h5, 32'h5, 32'h5);
		send_vertex(tpa_pkg::MODE_FAN, 0, 32'h6, 32'h6, 32'h6);
		send_vertex(tpa_pkg::MODE_NONE, 1, 32'h0, 32'h0, 32'h0);
		send_vertex(tpa_pkg::MODE_STRIP, 0, 32'h7, 32'h7, 32'h7);
		// hold off until every result has come
		drain();

		random_vertices(100);
		send_idle_pct = 57;
		random_vertices(100);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 57;
		random_vertices(100);
		send_idle_pct = 25;
		recv_stall_pct = 25;
		random_vertices(100);

		drain();
		repeat (20) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
